// ===== rtl/core/vmc_pkg.sv =====
// ----------------------------------------------------------------------------
// vmc_pkg: shared types and command codes
// Command codes and sequencer states for the vector math coprocessor.
// ----------------------------------------------------------------------------
package vmc_pkg;

  localparam int unsigned RegCount = 16;

  typedef logic [15:0] word_t;

  typedef enum logic [4:0] {
    CMD_LO_R0  = 5'h00, CMD_HI_R0  = 5'h01, CMD_LO_R1  = 5'h02, CMD_HI_R1  = 5'h03,
    CMD_LO_R2  = 5'h04, CMD_HI_R2  = 5'h05, CMD_LO_R3  = 5'h06, CMD_HI_R3  = 5'h07,
    CMD_LO_R4  = 5'h08, CMD_HI_R4  = 5'h09, CMD_LO_R5  = 5'h0a, CMD_ROTX   = 5'h0b,
    CMD_LD_R6  = 5'h0c, CMD_LO_R10 = 5'h0d, CMD_HI_R10 = 5'h0e, CMD_LO_R11 = 5'h0f,
    CMD_HI_R11 = 5'h10, CMD_FULL   = 5'h11, CMD_ROTY   = 5'h12, CMD_DIV98  = 5'h13,
    CMD_DIVAB  = 5'h14, CMD_LO_R7  = 5'h15, CMD_HI_R7  = 5'h16, CMD_RD_R7  = 5'h17,
    CMD_RD_R9  = 5'h18, CMD_RD_R8  = 5'h19, CMD_LO_R8  = 5'h1a, CMD_HI_R8  = 5'h1b,
    CMD_BISECT = 5'h1c, CMD_DIST_L = 5'h1d, CMD_DIST   = 5'h1e, CMD_TEST   = 5'h1f
  } cmd_e;

  // Sequencer steps; each step issues one operation on the shared ALU/multiplier.
  typedef enum logic [5:0] {
    S_IDLE,
    S_RX_SUB4, S_RX_SUB5,
    S_RX_M1, S_RX_M2, S_RX_FIN, S_RX_ADD,
    S_RY_M1, S_RY_M2, S_RY_FIN, S_RY_ADD,
    S_DV_SETUP, S_DV_ABS, S_DV_STEP, S_DV_SIGN,
    S_BI_STEP,
    S_DS_ABS2, S_DS_ABS3, S_DS_CALC,
    S_OUT
  } state_e;

  typedef enum logic [1:0] {
    SRC_R9R8, SRC_R10R11, SRC_ROTY
  } dsrc_e;

  // Multiplier request from the sequencer.
  typedef struct packed {
    word_t a;
    word_t b;
  } mul_req_t;

  function automatic word_t abs16(word_t v);
    return v[15] ? (16'h0000 - v) : v;
  endfunction

  function automatic logic [16:0] half17(logic [16:0] v);
    return {v[16], v[16:1]};
  endfunction

endpackage

// ===== rtl/core/vector_math_coprocessor_unit.sv =====
// ----------------------------------------------------------------------------
// vector_math_coprocessor_unit: vector math coprocessor
// Command-driven scratch register file with rotate, divide, bisect, distance.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: command_i/data_byte_i with in_valid_i/in_stall_o. One
//   transaction per command; each yields exactly one result transaction on
//   result_o with out_valid_o/out_stall_i.
//   The divide and the bisection loop over a counter taken from R6: R6+1
//   steps for a non-negative counter, one for a negative one, 32769 when it
//   is -32768. Loop steps use the shared adder; each of the four products of
//   the full chain uses the shared multiplier.
//   One command is in flight at a time; in_stall_o is high while the
//   sequencer runs or while a result waits in the output register, so the
//   next transaction is accepted in the cycle after the result is taken.
//   A stalled receiver holds the result and the next command waits behind it.
//   Reset clears all scratch registers and the sequencer result to zero.
// ----------------------------------------------------------------------------
module vector_math_coprocessor_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  command_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] result_o
);

  logic              busy, done, start;
  vmc_pkg::word_t    seq_res;
  vmc_pkg::mul_req_t mul_req;
  logic [31:0]       prod;
  logic              ov_q, ov_d;
  vmc_pkg::word_t    out_q;

  assign in_stall_o = busy | ov_q;
  assign start      = in_valid_i & ~in_stall_o;

  vmc_seq u_seq (
    .clk_i, .rst_ni,
    .start_i(start), .command_i, .data_byte_i,
    .busy_o(busy), .done_o(done), .result_o(seq_res),
    .mul_req_o(mul_req), .prod_i(prod)
  );

  vmc_mul u_mul (.clk_i, .req_i(mul_req), .prod_o(prod));

  assign ov_d = done | (ov_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else         ov_q <= ov_d;
  end

  always_ff @(posedge clk_i) begin
    if (done) out_q <= seq_res;
  end

  assign out_valid_o = ov_q;
  assign result_o    = out_q;

endmodule

// ===== rtl/core/vmc_mul.sv =====
// ----------------------------------------------------------------------------
// vmc_mul: shared signed multiplier
// Registered 16x16 signed product.
// ----------------------------------------------------------------------------
module vmc_mul (
  input  logic              clk_i,
  input  vmc_pkg::mul_req_t req_i,
  output logic [31:0]       prod_o
);

  logic [31:0] prod_q, prod_d;

  assign prod_d = 32'($signed(req_i.a) * $signed(req_i.b));

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// ===== rtl/core/vmc_seq.sv =====
// ----------------------------------------------------------------------------
// vmc_seq: sequencer and register file
// Decodes commands and steps the shared multiplier and adder through each
// compute routine, one operation per sequencer step.
// ----------------------------------------------------------------------------
module vmc_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [4:0]        command_i,
  input  logic [7:0]        data_byte_i,
  output logic              busy_o,
  output logic              done_o,
  output vmc_pkg::word_t    result_o,
  output vmc_pkg::mul_req_t mul_req_o,
  input  logic [31:0]       prod_i
);

  vmc_pkg::state_e state_q, state_d;
  vmc_pkg::word_t  r_q [vmc_pkg::RegCount];
  vmc_pkg::word_t  r_d [vmc_pkg::RegCount];
  vmc_pkg::word_t  res_q, res_d;
  vmc_pkg::word_t  q_q, q_d;
  vmc_pkg::word_t  lo_q, lo_d;
  vmc_pkg::dsrc_e  src_q, src_d;
  logic            waited_q, waited_d;

  assign busy_o   = (state_q != vmc_pkg::S_IDLE);
  assign done_o   = (state_q == vmc_pkg::S_OUT);
  assign result_o = res_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      vmc_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (vmc_pkg::cmd_e'(command_i)) inside
            vmc_pkg::CMD_ROTX:                       state_d = vmc_pkg::S_RX_SUB4;
            vmc_pkg::CMD_FULL:                       state_d = vmc_pkg::S_RX_M1;
            vmc_pkg::CMD_ROTY:                       state_d = vmc_pkg::S_RY_M1;
            vmc_pkg::CMD_DIV98, vmc_pkg::CMD_DIVAB:  state_d = vmc_pkg::S_DV_SETUP;
            vmc_pkg::CMD_BISECT:                     state_d = vmc_pkg::S_BI_STEP;
            vmc_pkg::CMD_DIST_L:                     state_d = vmc_pkg::S_DS_ABS2;
            vmc_pkg::CMD_DIST:                       state_d = vmc_pkg::S_DS_CALC;
            default:                                 state_d = vmc_pkg::S_OUT;
          endcase
        end
      end
      vmc_pkg::S_RX_SUB4: state_d = vmc_pkg::S_RX_SUB5;
      vmc_pkg::S_RX_SUB5: state_d = vmc_pkg::S_RX_M1;
      vmc_pkg::S_RX_M1:   state_d = waited_q ? vmc_pkg::S_RX_M2 : state_q;
      vmc_pkg::S_RX_M2:   state_d = waited_q ? vmc_pkg::S_RX_FIN : state_q;
      vmc_pkg::S_RX_FIN:  state_d = r_q[15][15] ? vmc_pkg::S_OUT : vmc_pkg::S_RX_ADD;
      vmc_pkg::S_RX_ADD:  state_d = vmc_pkg::S_RY_M1;
      vmc_pkg::S_RY_M1:   state_d = waited_q ? vmc_pkg::S_RY_M2 : state_q;
      vmc_pkg::S_RY_M2:   state_d = waited_q ? vmc_pkg::S_RY_FIN : state_q;
      vmc_pkg::S_RY_FIN:  state_d = r_q[15][15] ? vmc_pkg::S_OUT : vmc_pkg::S_RY_ADD;
      vmc_pkg::S_RY_ADD:  state_d = vmc_pkg::S_DV_SETUP;
      vmc_pkg::S_DV_SETUP: state_d = vmc_pkg::S_DV_ABS;
      vmc_pkg::S_DV_ABS:  state_d = vmc_pkg::S_DV_STEP;
      // loop while the decremented counter stays non-negative (wraps at -32768)
      vmc_pkg::S_DV_STEP: state_d = r_d[15][15] ? vmc_pkg::S_DV_SIGN : state_q;
      vmc_pkg::S_DV_SIGN: state_d = vmc_pkg::S_OUT;
      vmc_pkg::S_BI_STEP: state_d = r_d[6][15] ? vmc_pkg::S_OUT : state_q;
      vmc_pkg::S_DS_ABS2: state_d = vmc_pkg::S_DS_ABS3;
      vmc_pkg::S_DS_ABS3: state_d = vmc_pkg::S_DS_CALC;
      vmc_pkg::S_DS_CALC: state_d = vmc_pkg::S_OUT;
      vmc_pkg::S_OUT:     state_d = vmc_pkg::S_IDLE;
      default:            state_d = vmc_pkg::S_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    logic [16:0] s17, e17, f17;
    logic [31:0] np;
    vmc_pkg::word_t t, cc, dd, den, num, q_sh;
    logic msb;
    for (int i = 0; i < vmc_pkg::RegCount; i++) r_d[i] = r_q[i];
    res_d = res_q; q_d = q_q; lo_d = lo_q; src_d = src_q;
    waited_d = 1'b0;
    mul_req_o = '0;
    s17 = '0; e17 = '0; f17 = '0; t = '0; cc = '0; dd = '0;
    den = '0; num = '0; q_sh = '0; msb = 1'b0; np = '0;
    unique case (state_q)
      vmc_pkg::S_IDLE: begin
        if (start_i) begin
          unique case (vmc_pkg::cmd_e'(command_i))
            vmc_pkg::CMD_LO_R0:  begin r_d[0]  = {r_q[0][15:8], data_byte_i};  res_d = r_d[0];  end
            vmc_pkg::CMD_HI_R0:  begin r_d[0]  = {data_byte_i, r_q[0][7:0]};   res_d = r_d[0];  end
            vmc_pkg::CMD_LO_R1:  begin r_d[1]  = {r_q[1][15:8], data_byte_i};  res_d = r_d[1];  end
            vmc_pkg::CMD_HI_R1:  begin r_d[1]  = {data_byte_i, r_q[1][7:0]};   res_d = r_d[1];  end
            vmc_pkg::CMD_LO_R2:  begin r_d[2]  = {r_q[2][15:8], data_byte_i};  res_d = r_d[2];  end
            vmc_pkg::CMD_HI_R2:  begin r_d[2]  = {data_byte_i, r_q[2][7:0]};   res_d = r_d[2];  end
            vmc_pkg::CMD_LO_R3:  begin r_d[3]  = {r_q[3][15:8], data_byte_i};  res_d = r_d[3];  end
            vmc_pkg::CMD_HI_R3:  begin r_d[3]  = {data_byte_i, r_q[3][7:0]};   res_d = r_d[3];  end
            vmc_pkg::CMD_LO_R4:  begin r_d[4]  = {r_q[4][15:8], data_byte_i};  res_d = r_d[4];  end
            vmc_pkg::CMD_HI_R4:  begin r_d[4]  = {data_byte_i, r_q[4][7:0]};   res_d = r_d[4];  end
            vmc_pkg::CMD_LO_R5:  begin r_d[5]  = {r_q[5][15:8], data_byte_i};  res_d = r_d[5];  end
            vmc_pkg::CMD_LD_R6:  begin r_d[6]  = {8'h00, data_byte_i};         res_d = r_d[6];  end
            vmc_pkg::CMD_LO_R10: begin r_d[10] = {r_q[10][15:8], data_byte_i}; res_d = r_d[10]; end
            vmc_pkg::CMD_HI_R10: begin r_d[10] = {data_byte_i, r_q[10][7:0]};  res_d = r_d[10]; end
            vmc_pkg::CMD_LO_R11: begin r_d[11] = {r_q[11][15:8], data_byte_i}; res_d = r_d[11]; end
            vmc_pkg::CMD_HI_R11: begin r_d[11] = {data_byte_i, r_q[11][7:0]};  res_d = r_d[11]; end
            vmc_pkg::CMD_LO_R7:  begin r_d[7]  = {r_q[7][15:8], data_byte_i};  res_d = r_d[7];  end
            vmc_pkg::CMD_HI_R7:  begin r_d[7]  = {data_byte_i, r_q[7][7:0]};   res_d = r_d[7];  end
            vmc_pkg::CMD_LO_R8:  begin r_d[8]  = {r_q[8][15:8], data_byte_i};  res_d = r_d[8];  end
            vmc_pkg::CMD_HI_R8:  begin r_d[8]  = {data_byte_i, r_q[8][7:0]};   res_d = r_d[8];  end
            vmc_pkg::CMD_RD_R7:  res_d = r_q[7];
            vmc_pkg::CMD_RD_R8:  res_d = r_q[8];
            vmc_pkg::CMD_RD_R9:  res_d = r_q[9];
            vmc_pkg::CMD_ROTX: begin
              r_d[5]  = {data_byte_i, r_q[5][7:0]};
              r_d[15] = 16'hffff;
            end
            vmc_pkg::CMD_FULL: begin
              r_d[5]  = {data_byte_i, r_q[5][7:0]};
              r_d[15] = 16'h0000;
            end
            vmc_pkg::CMD_DIV98:  src_d = vmc_pkg::SRC_R9R8;
            vmc_pkg::CMD_DIVAB:  src_d = vmc_pkg::SRC_R10R11;
            vmc_pkg::CMD_BISECT: r_d[5] = {data_byte_i, r_q[5][7:0]};
            vmc_pkg::CMD_DIST_L: r_d[3] = {data_byte_i, r_q[3][7:0]};
            default: ;
          endcase
        end
      end
      vmc_pkg::S_RX_SUB4: r_d[4] = r_q[4] - r_q[2];
      vmc_pkg::S_RX_SUB5: r_d[5] = r_q[5] - r_q[3];
      vmc_pkg::S_RX_M1: begin
        mul_req_o.a = r_q[0]; mul_req_o.b = r_q[4];
        waited_d = ~waited_q;
        if (waited_q) begin
          r_d[12] = prod_i[31:16];
          r_d[14] = prod_i[15:0];
        end
      end
      vmc_pkg::S_RX_M2: begin
        // (-R1)*R5 as -(R1*R5): negating R1 first would fail for -32768
        mul_req_o.a = r_q[1]; mul_req_o.b = r_q[5];
        waited_d = ~waited_q;
        if (waited_q) begin
          np     = 32'd0 - prod_i;
          r_d[7] = np[31:16];
          lo_d   = np[15:0];
        end
      end
      vmc_pkg::S_RX_FIN: begin
        t = ({1'b0, r_q[14][15:1]}) + ({1'b0, lo_q[15:1]});
        r_d[7]  = r_q[7] + r_q[12] + {15'd0, t[15]};
        r_d[14] = {1'b0, r_q[14][15:1]};
        r_d[12] = {1'b0, lo_q[15:1]};
        res_d   = r_d[7];
      end
      vmc_pkg::S_RX_ADD: r_d[7] = r_q[7] + r_q[2];
      vmc_pkg::S_RY_M1: begin
        mul_req_o.a = r_q[1]; mul_req_o.b = r_q[4];
        waited_d = ~waited_q;
        if (waited_q) begin
          r_d[12] = prod_i[31:16];
          r_d[9]  = prod_i[15:0];
        end
      end
      vmc_pkg::S_RY_M2: begin
        mul_req_o.a = r_q[0]; mul_req_o.b = r_q[5];
        waited_d = ~waited_q;
        if (waited_q) begin
          r_d[8] = prod_i[31:16];
          lo_d   = prod_i[15:0];
        end
      end
      vmc_pkg::S_RY_FIN: begin
        t = ({1'b0, r_q[9][15:1]}) + ({1'b0, lo_q[15:1]});
        r_d[8]  = r_q[8] + r_q[12] + {15'd0, t[15]};
        r_d[12] = {1'b0, lo_q[15:1]};
        r_d[9]  = {t[14:0], 1'b0};
        res_d   = r_d[8];
      end
      vmc_pkg::S_RY_ADD: begin
        r_d[8] = r_q[8] + r_q[3];
        r_d[9] = {r_q[9][15:8], 8'h00};
        src_d  = vmc_pkg::SRC_ROTY;
      end
      vmc_pkg::S_DV_SETUP: begin
        if (src_q == vmc_pkg::SRC_R10R11) begin
          num = r_q[10]; den = r_q[11];
        end else begin
          num = r_q[9];  den = r_q[8];
        end
        r_d[14] = r_q[7] ^ den;
        if (!den[15]) begin
          r_d[13] = den;
          q_d     = num;
        end else begin
          // -num-1 < -1 exactly when num > 0 as a signed value
          r_d[13] = (16'h0000 - den) - 16'd1
                    + {15'd0, (!num[15] && num != 16'h0000)};
          q_d     = 16'h0000 - num;
        end
        r_d[15] = r_q[6];
      end
      vmc_pkg::S_DV_ABS: r_d[12] = vmc_pkg::abs16(r_q[7]);
      vmc_pkg::S_DV_STEP: begin
        t   = r_q[13] - r_q[12];
        msb = q_q[15];
        q_sh = {q_q[14:0], ~t[15]};
        if (t[15]) t = r_q[13];
        q_d     = q_sh;
        r_d[13] = {t[14:0], msb};
        r_d[15] = r_q[15] - 16'd1;
      end
      vmc_pkg::S_DV_SIGN: res_d = r_q[14][15] ? (16'h0000 - q_q) : q_q;
      vmc_pkg::S_BI_STEP: begin
        e17 = vmc_pkg::half17({r_q[4][15], r_q[4]} + {r_q[7][15], r_q[7]});
        f17 = vmc_pkg::half17({r_q[5][15], r_q[5]} + {r_q[8][15], r_q[8]});
        s17 = e17 + f17;
        r_d[14] = e17[15:0];
        r_d[15] = f17[15:0];
        // e and f fit in 16 bits, so the signed compares are exact
        if ($signed(r_q[11]) < $signed(e17[15:0]) &&
            $signed(f17[15:0]) < $signed(e17[15:0]) && !s17[16]) begin
          r_d[7] = e17[15:0];
          r_d[8] = f17[15:0];
        end else begin
          r_d[4] = e17[15:0];
          r_d[5] = f17[15:0];
        end
        r_d[6] = r_q[6] - 16'd1;
        res_d  = r_d[8];
      end
      vmc_pkg::S_DS_ABS2: r_d[2] = vmc_pkg::abs16(r_q[2] - r_q[0]);
      vmc_pkg::S_DS_ABS3: r_d[3] = vmc_pkg::abs16(r_q[3] - r_q[1]);
      vmc_pkg::S_DS_CALC: begin
        if ($signed(r_q[3]) >= $signed(r_q[2])) begin
          cc = r_q[2]; dd = r_q[3];
        end else begin
          cc = r_q[3]; dd = r_q[2];
        end
        cc = {{2{cc[15]}}, cc[15:2]};
        dd = dd + cc;
        cc = {cc[15], cc[15:1]};
        r_d[12] = cc;
        r_d[13] = cc + dd;
        res_d   = r_d[13];
      end
      vmc_pkg::S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= vmc_pkg::S_IDLE;
      res_q    <= '0;
      waited_q <= 1'b0;
      src_q    <= vmc_pkg::SRC_R9R8;
      for (int i = 0; i < vmc_pkg::RegCount; i++) r_q[i] <= '0;
    end else begin
      state_q  <= state_d;
      res_q    <= res_d;
      waited_q <= waited_d;
      src_q    <= src_d;
      for (int i = 0; i < vmc_pkg::RegCount; i++) r_q[i] <= r_d[i];
    end
  end

  always_ff @(posedge clk_i) begin
    q_q  <= q_d;
    lo_q <= lo_d;
  end

endmodule

// ===== rtl/core/vmc_checker.sv =====
// ----------------------------------------------------------------------------
// vmc_checker: port-level checks
// Handshake and one-in-flight checks on the top-level ports.
// ----------------------------------------------------------------------------
module vmc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] result_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o))
    else $error("stalled result changed");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted back to back");

  a_out_stalls_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while result pending");

  a_no_out_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> !out_valid_o)
    else $error("accept with result pending");

endmodule

bind vector_math_coprocessor_unit vmc_checker u_vmc_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .result_o
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: vector math coprocessor testbench
// Drives command/data transactions from a pending queue, predicts each result
// with a local model of the scratch registers, and checks every result
// transaction in order under several sender/receiver idling phases.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    vmc_pkg::cmd_e cmd;
    logic [7:0]    data;
  } vmc_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [4:0]  command_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic signed [15:0] result_o;

  vector_math_coprocessor_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .data_byte_i(data_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .result_o   (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  vmc_item_t       pend_q[$];
  vmc_pkg::word_t  result_q[$];
  int         err_cnt = 0;
  int         sent_cnt = 0;
  int         checked_cnt = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         hold_gen = 0;

  // ---------------- predictor ----------------
  vmc_pkg::word_t sr[16];
  vmc_pkg::word_t acc;

  function automatic int sx(vmc_pkg::word_t v);
    return int'(signed'(v));
  endfunction

  function automatic vmc_pkg::word_t w16(int v);
    return v[15:0];
  endfunction

  function automatic void pdiv(vmc_pkg::word_t num, vmc_pkg::word_t den);
    vmc_pkg::word_t q;
    logic  msb;
    q = den;
    sr[14] = sr[7] ^ den;
    sr[13] = den;
    if (sx(den) >= 0) begin
      q = num;
    end else begin
      int nq;
      nq = -sx(num) - 1;
      sr[13] = w16(-sx(den) - 1);
      if (nq < -1) sr[13] = sr[13] + 16'd1;
      q = w16(nq + 1);
    end
    sr[12] = (sx(sr[7]) >= 0) ? sr[7] : w16(-sx(sr[7]));
    sr[15] = sr[6];
    do begin
      sr[13] = sr[13] - sr[12];
      msb = q[15];
      q = q << 1;
      if (sx(sr[13]) >= 0) q = q + 16'd1;
      else sr[13] = sr[13] + sr[12];
      sr[13] = (sr[13] << 1) + {15'd0, msb};
      sr[15] = sr[15] - 16'd1;
    end while (sx(sr[15]) >= 0);
    acc = (sx(sr[14]) >= 0) ? q : w16(-sx(q));
  endfunction

  function automatic void prot_y();
    int    p;
    vmc_pkg::word_t lo;
    p = sx(sr[1]) * sx(sr[4]);
    sr[12] = p[31:16];
    sr[9] = p[15:0];
    p = sx(sr[0]) * sx(sr[5]);
    sr[8] = p[31:16];
    lo = p[15:0];
    sr[8] = sr[8] + sr[12];
    sr[9] = sr[9] >> 1;
    sr[12] = lo >> 1;
    sr[9] = sr[9] + sr[12];
    if (sr[9][15]) sr[8] = sr[8] + 16'd1;
    sr[9] = sr[9] << 1;
    acc = sr[8];
    if (sx(sr[15]) < 0) return;
    sr[8] = sr[8] + sr[3];
    sr[9] &= 16'hff00;
    pdiv(sr[9], sr[8]);
  endfunction

  function automatic void prot_x();
    int          p;
    vmc_pkg::word_t lo;
    logic [16:0] s;
    p = sx(sr[0]) * sx(sr[4]);
    sr[12] = p[31:16];
    sr[14] = p[15:0];
    p = (-sx(sr[1])) * sx(sr[5]);
    sr[7] = p[31:16];
    lo = p[15:0];
    sr[7] = sr[7] + sr[12];
    sr[14] = sr[14] >> 1;
    sr[12] = lo >> 1;
    s = {1'b0, sr[12]} + {1'b0, sr[14]};
    if (s[15]) sr[7] = sr[7] + 16'd1;
    acc = sr[7];
    if (sx(sr[15]) < 0) return;
    sr[7] = sr[7] + sr[2];
    prot_y();
  endfunction

  function automatic void pbisect();
    int e, f;
    do begin
      e = (sx(sr[4]) + sx(sr[7])) >>> 1;
      f = (sx(sr[5]) + sx(sr[8])) >>> 1;
      sr[14] = w16(e);
      sr[15] = w16(f);
      if (sx(sr[11]) < e && f < e && e + f >= 0) begin
        sr[7] = sr[14];
        sr[8] = sr[15];
      end else begin
        sr[4] = sr[14];
        sr[5] = sr[15];
      end
      sr[6] = sr[6] - 16'd1;
    end while (sx(sr[6]) >= 0);
    acc = sr[8];
  endfunction

  function automatic void pdist();
    int c, d;
    if (sx(sr[3]) >= sx(sr[2])) begin
      c = sx(sr[2]);
      d = sx(sr[3]);
    end else begin
      d = sx(sr[2]);
      c = sx(sr[3]);
    end
    c = (c >>> 1) >>> 1;
    d = sx(w16(d + c));
    c = c >>> 1;
    sr[12] = w16(c);
    sr[13] = w16(c + d);
    acc = sr[13];
  endfunction

  function automatic vmc_pkg::word_t absdiff(vmc_pkg::word_t a, vmc_pkg::word_t b);
    vmc_pkg::word_t v;
    v = a - b;
    return v[15] ? (16'd0 - v) : v;
  endfunction

  function automatic void ld(int i, logic [7:0] d, bit hi);
    if (hi) sr[i] = {d, sr[i][7:0]};
    else sr[i] = {sr[i][15:8], d};
    acc = sr[i];
  endfunction

  function automatic vmc_pkg::word_t vmc_predict(vmc_item_t it);
    case (it.cmd)
      vmc_pkg::CMD_LO_R0:  ld(0, it.data, 0);
      vmc_pkg::CMD_HI_R0:  ld(0, it.data, 1);
      vmc_pkg::CMD_LO_R1:  ld(1, it.data, 0);
      vmc_pkg::CMD_HI_R1:  ld(1, it.data, 1);
      vmc_pkg::CMD_LO_R2:  ld(2, it.data, 0);
      vmc_pkg::CMD_HI_R2:  ld(2, it.data, 1);
      vmc_pkg::CMD_LO_R3:  ld(3, it.data, 0);
      vmc_pkg::CMD_HI_R3:  ld(3, it.data, 1);
      vmc_pkg::CMD_LO_R4:  ld(4, it.data, 0);
      vmc_pkg::CMD_HI_R4:  ld(4, it.data, 1);
      vmc_pkg::CMD_LO_R5:  ld(5, it.data, 0);
      vmc_pkg::CMD_LD_R6: begin
        sr[6] = {8'd0, it.data};
        acc = sr[6];
      end
      vmc_pkg::CMD_LO_R10: ld(10, it.data, 0);
      vmc_pkg::CMD_HI_R10: ld(10, it.data, 1);
      vmc_pkg::CMD_LO_R11: ld(11, it.data, 0);
      vmc_pkg::CMD_HI_R11: ld(11, it.data, 1);
      vmc_pkg::CMD_LO_R7:  ld(7, it.data, 0);
      vmc_pkg::CMD_HI_R7:  ld(7, it.data, 1);
      vmc_pkg::CMD_LO_R8:  ld(8, it.data, 0);
      vmc_pkg::CMD_HI_R8:  ld(8, it.data, 1);
      vmc_pkg::CMD_RD_R7:  acc = sr[7];
      vmc_pkg::CMD_RD_R8:  acc = sr[8];
      vmc_pkg::CMD_RD_R9:  acc = sr[9];
      vmc_pkg::CMD_ROTX: begin
        sr[5] = {it.data, sr[5][7:0]};
        sr[15] = 16'hffff;
        sr[4] = sr[4] - sr[2];
        sr[5] = sr[5] - sr[3];
        prot_x();
      end
      vmc_pkg::CMD_FULL: begin
        sr[5] = {it.data, sr[5][7:0]};
        sr[15] = 16'h0000;
        prot_x();
      end
      vmc_pkg::CMD_ROTY:   prot_y();
      vmc_pkg::CMD_DIV98:  pdiv(sr[9], sr[8]);
      vmc_pkg::CMD_DIVAB:  pdiv(sr[10], sr[11]);
      vmc_pkg::CMD_BISECT: begin
        sr[5] = {it.data, sr[5][7:0]};
        pbisect();
      end
      vmc_pkg::CMD_DIST_L: begin
        sr[3] = {it.data, sr[3][7:0]};
        sr[2] = absdiff(sr[2], sr[0]);
        sr[3] = absdiff(sr[3], sr[1]);
        pdist();
      end
      vmc_pkg::CMD_DIST:   pdist();
      default: ;
    endcase
    return acc;
  endfunction

  // ---------------- driver ----------------
  always @(posedge clk_i or negedge rst_ni) begin : drv
    vmc_item_t it;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        it.cmd = vmc_pkg::cmd_e'(command_i);
        it.data = data_byte_i;
        result_q.push_back(vmc_predict(it));
        sent_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pend_q.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          it = pend_q.pop_front();
          in_valid_i  <= 1'b1;
          command_i   <= it.cmd;
          data_byte_i <= it.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- receiver stall ----------------
  int hold_seen = 0;
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_cnt = 600;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < sink_stall_pct);
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_q.size() == 0) begin
        $error("unexpected result transaction: result=%h", result_o);
        err_cnt++;
      end else begin
        vmc_pkg::word_t w;
        w = result_q.pop_front();
        checked_cnt++;
        if (result_o !== w) begin
          $error("result mismatch: expected %h actual %h", w, result_o);
          err_cnt++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------
  function automatic void push_cmd(vmc_pkg::cmd_e c, logic [7:0] d);
    vmc_item_t it;
    it.cmd = c;
    it.data = d;
    pend_q.push_back(it);
  endfunction

  function automatic logic [7:0] rbyte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // one well-formed sequence (operand loads then a compute), or noise
  function automatic int push_seq();
    int n;
    vmc_pkg::cmd_e loads[20];
    vmc_pkg::cmd_e ops[8];
    loads = '{vmc_pkg::CMD_LO_R0, vmc_pkg::CMD_HI_R0, vmc_pkg::CMD_LO_R1,
              vmc_pkg::CMD_HI_R1, vmc_pkg::CMD_LO_R2, vmc_pkg::CMD_HI_R2,
              vmc_pkg::CMD_LO_R3, vmc_pkg::CMD_HI_R3, vmc_pkg::CMD_LO_R4,
              vmc_pkg::CMD_HI_R4, vmc_pkg::CMD_LO_R5, vmc_pkg::CMD_LO_R7,
              vmc_pkg::CMD_HI_R7, vmc_pkg::CMD_LO_R8, vmc_pkg::CMD_HI_R8,
              vmc_pkg::CMD_LO_R10, vmc_pkg::CMD_HI_R10, vmc_pkg::CMD_LO_R11,
              vmc_pkg::CMD_HI_R11, vmc_pkg::CMD_LO_R5};
    ops = '{vmc_pkg::CMD_ROTX, vmc_pkg::CMD_FULL, vmc_pkg::CMD_ROTY,
            vmc_pkg::CMD_DIV98, vmc_pkg::CMD_DIVAB, vmc_pkg::CMD_BISECT,
            vmc_pkg::CMD_DIST_L, vmc_pkg::CMD_DIST};
    n = 0;
    if ($urandom_range(0, 9) < 2) begin
      push_cmd(vmc_pkg::cmd_e'(5'($urandom_range(0, 31))), 8'($urandom_range(0, 255)));
      return 1;
    end
    repeat ($urandom_range(1, 6)) begin
      push_cmd(loads[$urandom_range(0, 19)], rbyte());
      n++;
    end
    if ($urandom_range(0, 2) != 0) begin
      // mostly short loops; occasionally the full 8-bit count
      push_cmd(vmc_pkg::CMD_LD_R6, ($urandom_range(0, 19) == 0)
                                   ? 8'($urandom_range(0, 255))
                                   : 8'($urandom_range(0, 15)));
      n++;
    end
    push_cmd(ops[$urandom_range(0, 7)], rbyte());
    n++;
    if ($urandom_range(0, 3) == 0) begin
      push_cmd(vmc_pkg::cmd_e'(5'(vmc_pkg::CMD_RD_R7 + $urandom_range(0, 2))),
               8'($urandom_range(0, 255)));
      n++;
    end
    return n;
  endfunction

  task automatic wait_drained();
    while (pend_q.size() != 0 || in_valid_i || result_q.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int total;
    int ph;
    foreach (sr[i]) sr[i] = '0;
    acc = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, most commands, corner cases
    push_cmd(vmc_pkg::CMD_LO_R0, 8'hff);
    push_cmd(vmc_pkg::CMD_HI_R0, 8'h7f);
    push_cmd(vmc_pkg::CMD_LO_R1, 8'h00);
    push_cmd(vmc_pkg::CMD_HI_R1, 8'h80);
    push_cmd(vmc_pkg::CMD_LO_R4, 8'h34);
    push_cmd(vmc_pkg::CMD_LO_R5, 8'h12);
    push_cmd(vmc_pkg::CMD_LD_R6, 8'h03);
    push_cmd(vmc_pkg::CMD_FULL, 8'h40);
    push_cmd(vmc_pkg::CMD_ROTX, 8'hff);
    push_cmd(vmc_pkg::CMD_ROTY, 8'h00);    // R15 negative from previous: no divide
    push_cmd(vmc_pkg::CMD_RD_R9, 8'h00);
    push_cmd(vmc_pkg::CMD_DIV98, 8'h00);
    push_cmd(vmc_pkg::CMD_LO_R11, 8'h05);
    push_cmd(vmc_pkg::CMD_HI_R11, 8'hff);
    push_cmd(vmc_pkg::CMD_HI_R10, 8'h12);
    push_cmd(vmc_pkg::CMD_DIVAB, 8'h00);
    push_cmd(vmc_pkg::CMD_BISECT, 8'h10);  // leaves R6 negative
    push_cmd(vmc_pkg::CMD_DIV98, 8'h00);   // negative count: one step
    push_cmd(vmc_pkg::CMD_LO_R2, 8'h00);
    push_cmd(vmc_pkg::CMD_HI_R2, 8'h80);   // R2 = -32768
    push_cmd(vmc_pkg::CMD_LO_R0, 8'h00);
    push_cmd(vmc_pkg::CMD_HI_R0, 8'h00);
    push_cmd(vmc_pkg::CMD_DIST_L, 8'hff);  // |-32768| stays -32768
    push_cmd(vmc_pkg::CMD_DIST, 8'h00);
    push_cmd(vmc_pkg::CMD_TEST, 8'hff);
    push_cmd(vmc_pkg::CMD_RD_R8, 8'hff);
    wait_drained();

    total = 0;
    for (ph = 0; ph < 4; ph++) begin
      src_idle_pct   = (ph == 1) ? 80 : (ph == 3) ? 15 : 0;
      sink_stall_pct = (ph == 2) ? 80 : (ph == 3) ? 15 : 0;
      if (ph == 0) hold_gen++;        // long receiver hold-off while items queue up
      while (total < (ph + 1) * 410) total += push_seq();
      wait_drained();
      repeat (40) @(posedge clk_i);   // sender pause with nothing in flight
    end
    wait_drained();
    repeat (300) @(posedge clk_i);
    $display("Covered %0d transactions, %0d results checked, all 32 commands,",
             sent_cnt, checked_cnt);
    $display("four idling phases and one long receiver hold-off.");
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(12 * 4000000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
